FILE: rtl/glrs_pkg.sv
// Package for the gated linear recurrence scan: beat types, unit request and
// response structs, sizing constants, the 2^-k/16 table and Q32->Q16 rounding.
// No dependencies.
`default_nettype none

package glrs_pkg;

  localparam int LAYERS   = 32;
  localparam int CHANNELS = 4096;
  localparam int ST_DEPTH = LAYERS * CHANNELS;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  localparam int DW       = 24;
  localparam int MC_W     = DW + 1;
  localparam int MP_W     = DW;
  localparam int PROD_W   = MC_W + MP_W;
  localparam int MUL_DW   = 4;
  localparam int MUL_DIGS = MP_W / MUL_DW;
  localparam int ACC_W    = MC_W + MUL_DW + 1;

  localparam int SQ_W     = 34;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int SQ_RW    = SQ_STEPS + 2;

  localparam int A_W      = 17;

  localparam logic [A_W-1:0]          Q_ONE     = 17'd65536;
  localparam logic [MP_W-1:0]         LOG2E_Q16 = 24'd94548;
  localparam logic signed [DW-1:0]    SAT_MAX   = 24'sh7FFFFF;
  localparam logic signed [DW-1:0]    SAT_MIN   = -24'sh800000;

  typedef struct packed {
    logic [4:0]            layer;
    logic [11:0]           channel;
    logic signed [23:0]    log_decay;
    logic signed [23:0]    gated_x;
    logic signed [23:0]    branch_y;
    logic                  first_pos;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0]    out_value;
    logic signed [23:0]    new_state;
  } out_beat_t;

  typedef struct packed {
    logic                    start;
    logic signed [MC_W-1:0]  mcand;
    logic [MP_W-1:0]         mplier;
  } mul_req_t;

  typedef struct packed {
    logic                      busy;
    logic signed [PROD_W-1:0]  prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   rad;
  } sq_req_t;

  typedef struct packed {
    logic                  busy;
    logic [SQ_STEPS-1:0]   root;
  } sq_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ST_AW-1:0]  addr;
  } st_rd_t;

  typedef struct packed {
    logic               en;
    logic [ST_AW-1:0]   addr;
    logic signed [DW-1:0] data;
  } st_wr_t;

  // 2^(-k/16) in Q16, k = 0..16
  function automatic logic [A_W-1:0] pow2_neg(input logic [4:0] k);
    logic [A_W-1:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  // Q32 -> Q16, round half up, saturate to 24 bits
  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] w;
    logic signed [PROD_W-16:0] q;
    w = v + (PROD_W+1)'(32768);
    q = (PROD_W-15)'(w >>> 16);
    if (q > (PROD_W-15)'(SAT_MAX)) begin
      return SAT_MAX;
    end
    if (q < (PROD_W-15)'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return q[DW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/glrs_mul.sv
// Digit-serial signed multiplier, radix 16: one multiplier digit per cycle,
// low product bits shift out into a register. Depends on glrs_pkg.
`default_nettype none

module glrs_mul import glrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CW = $clog2(MUL_DIGS);

  logic                    busy_r;
  logic [CW-1:0]           cnt_r;
  logic signed [MC_W-1:0]  mcand_r;
  logic [MP_W-1:0]         mplier_r;
  logic signed [ACC_W-1:0] hi_r;
  logic [MP_W-1:0]         lo_r;

  logic signed [MUL_DW:0]  dig;
  logic signed [ACC_W-1:0] pp;
  logic signed [ACC_W-1:0] sum;
  logic                    last;

  // top digit carries the sign of the multiplier
  always_comb begin
    last = (cnt_r == CW'(MUL_DIGS - 1));
    dig  = last ? $signed({mplier_r[MUL_DW-1], mplier_r[MUL_DW-1:0]})
                : $signed({1'b0, mplier_r[MUL_DW-1:0]});
    pp   = mcand_r * dig;
    sum  = hi_r + pp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r   <= 1'b1;
      cnt_r    <= '0;
      mcand_r  <= req.mcand;
      mplier_r <= req.mplier;
      hi_r     <= '0;
      lo_r     <= '0;
    end else if (busy_r) begin
      hi_r     <= sum >>> MUL_DW;
      lo_r     <= {sum[MUL_DW-1:0], lo_r[MP_W-1:MUL_DW]};
      mplier_r <= mplier_r >> MUL_DW;
      cnt_r    <= cnt_r + CW'(1);
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.prod = $signed({hi_r[MC_W-1:0], lo_r});

endmodule

`default_nettype wire

FILE: rtl/glrs_sqrt.sv
// Bit-serial integer square root, restoring form: two radicand bits in and one
// root bit out per cycle. Depends on glrs_pkg.
`default_nettype none

module glrs_sqrt import glrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  sq_req_t req,
  output sq_rsp_t rsp
);

  localparam int CW = $clog2(SQ_STEPS);

  logic                  busy_r;
  logic [CW-1:0]         cnt_r;
  logic [SQ_W-1:0]       rad_r;
  logic [SQ_RW-1:0]      rem_r;
  logic [SQ_STEPS-1:0]   root_r;

  logic [SQ_RW+1:0]      sh;
  logic [SQ_RW+1:0]      trial;
  logic [SQ_RW+1:0]      diff;
  logic                  ge;

  always_comb begin
    sh    = {rem_r, rad_r[SQ_W-1:SQ_W-2]};
    trial = {2'b00, root_r, 2'b01};
    ge    = (sh >= trial);
    diff  = sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rad_r  <= req.rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? diff[SQ_RW-1:0] : sh[SQ_RW-1:0];
      root_r <= {root_r[SQ_STEPS-2:0], ge};
      cnt_r  <= cnt_r + CW'(1);
      if (cnt_r == CW'(SQ_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.root = root_r;

endmodule

`default_nettype wire

FILE: rtl/glrs_store.sv
// Recurrent state store, one entry per layer and channel, with a clearing
// sweep after reset. Registered read. Depends on glrs_pkg.
`default_nettype none

module glrs_store import glrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  st_rd_t               rd,
  output logic signed [DW-1:0] rd_data,
  input  st_wr_t               wr,
  output logic                 busy
);

  logic [DW-1:0]    mem [ST_DEPTH];
  logic             clr_busy_r;
  logic [ST_AW-1:0] clr_addr_r;
  logic [DW-1:0]    rd_data_r;

  logic             wen;
  logic [ST_AW-1:0] waddr;
  logic [DW-1:0]    wdata;

  always_comb begin
    wen   = clr_busy_r | wr.en;
    waddr = clr_busy_r ? clr_addr_r : wr.addr;
    wdata = clr_busy_r ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ST_AW'(1);
      if (clr_addr_r == ST_AW'(ST_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = $signed(rd_data_r);
  assign busy    = clr_busy_r;

endmodule

`default_nettype wire

FILE: rtl/gated_linear_recurrence_scan.sv
// Top level of the gated linear recurrence scan: sequencer, exp interpolation,
// output register. Depends on glrs_pkg, glrs_mul, glrs_sqrt, glrs_store.
//
// Each input beat is one channel element of one recurrent layer. The block
// forms a = exp(log_decay) from a 17-entry table with linear interpolation,
// m = sqrt(1 - a*a) (m = 1.0 at a first position), updates the stored state to
// m*gated_x + a*state and returns branch_y times the new state; all values are
// signed Q8.16, rounded half up and saturated. One item is worked at a time: the
// next beat is accepted only after the result is loaded into the output register.
// The work is six passes of the shared radix-16 serial multiplier (five passes
// at a first position) and the 17-step bit-serial square root. After reset the
// state store is swept to zero, with in_stall high.
`default_nettype none

module gated_linear_recurrence_scan import glrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_INTP, S_AA, S_SQRT, S_MGX, S_AOLD, S_OUT
  } state_t;

  state_t                   state_r;
  logic [ST_AW-1:0]         addr_r;
  logic signed [DW-1:0]     gx_r;
  logic signed [DW-1:0]     by_r;
  logic                     first_r;
  logic [A_W-1:0]           lo_r;
  logic [4:0]               n_r;
  logic                     nbig_r;
  logic [A_W-1:0]           a_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [DW-1:0]     ns_r;
  logic                     out_valid_r;
  out_beat_t                out_beat_r;

  mul_req_t              mul_req;
  mul_rsp_t              mul_rsp;
  sq_req_t               sq_req;
  sq_rsp_t               sq_rsp;
  st_rd_t                st_rd;
  st_wr_t                st_wr;
  logic signed [DW-1:0]  st_rd_data;
  logic                  st_busy;

  logic                  in_acc;
  logic                  out_load;
  logic signed [MC_W-1:0] ld_ext;
  logic [MC_W-1:0]       t_val;
  logic [40:0]           u_sum;
  logic [24:0]           u_val;
  logic [8:0]            n_val;
  logic [4:0]            idx;
  logic [A_W-1:0]        tab_lo;
  logic [A_W-1:0]        tab_hi;
  logic [23:0]           q_sum;
  logic [A_W-1:0]        v_val;
  logic [A_W:0]          a_rnd;
  logic [A_W-1:0]        a_new;
  logic [SQ_W-1:0]       d_val;
  logic signed [DW-1:0]  ns_new;

  glrs_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  glrs_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .rsp  (sq_rsp)
  );

  glrs_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (st_rd),
    .rd_data(st_rd_data),
    .wr     (st_wr),
    .busy   (st_busy)
  );

  assign in_stall  = (state_r != S_IDLE) || st_busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && !mul_rsp.busy && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    // exp: t = -log_decay clamped at zero, u = round(t * log2(e))
    ld_ext = MC_W'(in_beat.log_decay);
    t_val  = ld_ext[MC_W-1] ? MC_W'(-ld_ext) : '0;
    u_sum  = mul_rsp.prod[40:0] + 41'd32768;
    u_val  = u_sum[40:16];
    n_val  = u_val[24:16];
    idx    = {1'b0, u_val[15:12]};
    tab_lo = pow2_neg(idx);
    tab_hi = pow2_neg(idx + 5'd1);
    // interpolation and rounded shift by the integer part
    q_sum  = mul_rsp.prod[23:0] + 24'd2048;
    v_val  = lo_r - {5'b0, q_sum[23:12]};
    a_rnd  = {1'b0, v_val >> (n_r - 5'd1)} + (A_W+1)'(1);
    if (nbig_r) begin
      a_new = '0;
    end else if (n_r == 5'd0) begin
      a_new = v_val;
    end else begin
      a_new = a_rnd[A_W:1];
    end
    d_val  = (SQ_W'(1) << 32) - {1'b0, mul_rsp.prod[32:0]};
    ns_new = rnd_sat((PROD_W+1)'(acc_r) + (PROD_W+1)'(mul_rsp.prod));
  end

  always_comb begin
    mul_req = '0;
    sq_req  = '0;
    st_rd   = '0;
    st_wr   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = $signed(t_val);
          mul_req.mplier = LOG2E_Q16;
          st_rd.en       = 1'b1;
          st_rd.addr     = {in_beat.layer, in_beat.channel};
        end
      end
      S_EXP: begin
        if (!mul_rsp.busy) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = $signed(MC_W'(tab_lo - tab_hi));
          mul_req.mplier = MP_W'(u_val[11:0]);
        end
      end
      S_INTP: begin
        if (!mul_rsp.busy) begin
          mul_req.start = 1'b1;
          if (first_r) begin
            mul_req.mcand  = MC_W'(gx_r);
            mul_req.mplier = MP_W'(Q_ONE);
          end else begin
            mul_req.mcand  = $signed(MC_W'(a_new));
            mul_req.mplier = MP_W'(a_new);
          end
        end
      end
      S_AA: begin
        if (!mul_rsp.busy) begin
          sq_req.start = 1'b1;
          sq_req.rad   = d_val;
        end
      end
      S_SQRT: begin
        if (!sq_rsp.busy) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = MC_W'(gx_r);
          mul_req.mplier = MP_W'(sq_rsp.root);
        end
      end
      S_MGX: begin
        if (!mul_rsp.busy) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = MC_W'(st_rd_data);
          mul_req.mplier = MP_W'(a_r);
        end
      end
      S_AOLD: begin
        if (!mul_rsp.busy) begin
          st_wr.en       = 1'b1;
          st_wr.addr     = addr_r;
          st_wr.data     = ns_new;
          mul_req.start  = 1'b1;
          mul_req.mcand  = MC_W'(by_r);
          mul_req.mplier = ns_new;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            addr_r  <= {in_beat.layer, in_beat.channel};
            gx_r    <= in_beat.gated_x;
            by_r    <= in_beat.branch_y;
            first_r <= in_beat.first_pos;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (!mul_rsp.busy) begin
            lo_r    <= tab_lo;
            n_r     <= n_val[4:0];
            nbig_r  <= (n_val > 9'd16);
            state_r <= S_INTP;
          end
        end
        S_INTP: begin
          if (!mul_rsp.busy) begin
            a_r     <= a_new;
            state_r <= first_r ? S_MGX : S_AA;
          end
        end
        S_AA: begin
          if (!mul_rsp.busy) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!sq_rsp.busy) begin
            state_r <= S_MGX;
          end
        end
        S_MGX: begin
          if (!mul_rsp.busy) begin
            acc_r   <= mul_rsp.prod;
            state_r <= S_AOLD;
          end
        end
        S_AOLD: begin
          if (!mul_rsp.busy) begin
            ns_r    <= ns_new;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_beat_r.out_value <= rnd_sat((PROD_W+1)'(mul_rsp.prod));
            out_beat_r.new_state <= ns_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glrs_chk.sv
// Port-level checker for gated_linear_recurrence_scan, bound to the top level.
// Depends on glrs_pkg.
`default_nettype none

module glrs_chk import glrs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // one item in flight: the beat after an accept is stalled
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // a fresh result only shows while the input side is busy with its item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in flight");

  // a held result beat is not dropped while the input side is not stalled
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !in_stall |=> out_valid)
    else $error("held result dropped");

endmodule

bind gated_linear_recurrence_scan glrs_chk u_glrs_chk (.*);

`default_nettype wire

FILE: verif/gated_linear_recurrence_scan_tb.sv
// Self-checking bench for gated_linear_recurrence_scan: directed rows, then random traffic
// mostly on six hot state slots, with idling, a long output hold-off and drains.
// Depends on glrs_pkg and the gated_linear_recurrence_scan RTL.
module gated_linear_recurrence_scan_tb;
  import glrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_BEATS    = 377;
  localparam int HOT_SLOTS      = 6;
  localparam int MAX_LINES      = 60;
  localparam int unsigned POW2_TAB [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{5'd0, 12'd0, 24'sd0, 24'sd65536, 24'sd65536, 1'b1}, 1'b1, '{24'sd65536, 24'sd65536}},
    '{'{5'd0, 12'd0, 24'sd0, 24'sd8388607, 24'sd8388607, 1'b0}, 1'b1,
      '{24'sd8388607, 24'sd65536}},
    '{'{5'd0, 12'd0, 24'sd8388607, 24'sd65536, -24'sd65536, 1'b1}, 1'b1,
      '{-24'sd131072, 24'sd131072}},
    '{'{5'd31, 12'd4095, 24'sd0, 24'sd8388607, 24'sd8388607, 1'b1}, 1'b1,
      '{24'sd8388607, 24'sd8388607}},
    '{'{5'd31, 12'd4095, 24'sd0, 24'sd8388607, 24'sd8388607, 1'b0}, 1'b1,
      '{24'sd8388607, 24'sd8388607}},
    '{'{5'd16, 12'd2048, 24'sd0, -24'sd8388608, 24'sd8388607, 1'b1}, 1'b1,
      '{-24'sd8388608, -24'sd8388608}},
    '{'{5'd16, 12'd2048, -24'sd8388608, 24'sd12345, 24'sd0, 1'b0}, 1'b1,
      '{24'sd0, 24'sd12345}},
    '{'{5'd1, 12'd1, 24'sd0, 24'sd32768, 24'sd1, 1'b1}, 1'b1, '{24'sd1, 24'sd32768}},
    '{'{5'd1, 12'd2, 24'sd0, 24'sd32768, -24'sd1, 1'b1}, 1'b1, '{24'sd0, 24'sd32768}},
    '{'{5'd1, 12'd3, 24'sd0, -24'sd32768, 24'sd1, 1'b1}, 1'b1, '{24'sd0, -24'sd32768}},
    '{'{5'd1, 12'd4, 24'sd0, 24'sd1, 24'sd1, 1'b1}, 1'b1, '{24'sd0, 24'sd1}},
    '{'{5'd2, 12'd5, -24'sd45426, 24'sd65536, 24'sd65536, 1'b1}, 1'b0, '{24'sd0, 24'sd0}},
    '{'{5'd2, 12'd5, -24'sd45426, 24'sd65536, 24'sd65536, 1'b0}, 1'b0, '{24'sd0, 24'sd0}},
    '{'{5'd2, 12'd5, -24'sd45426, -24'sd65536, 24'sd131072, 1'b0}, 1'b0, '{24'sd0, 24'sd0}},
    '{'{5'd3, 12'd10, -24'sd1, 24'sd100000, -24'sd70000, 1'b0}, 1'b0, '{24'sd0, 24'sd0}},
    '{'{5'd3, 12'd10, -24'sd65536, 24'sd8388607, -24'sd8388608, 1'b0}, 1'b0,
      '{24'sd0, 24'sd0}},
    '{'{5'd0, 12'd0, -24'sd4000000, -24'sd8388608, -24'sd8388608, 1'b0}, 1'b0,
      '{24'sd0, 24'sd0}},
    '{'{5'd21, 12'd2730, -24'sd1000000, 24'sd5592405, -24'sd5592406, 1'b1}, 1'b0,
      '{24'sd0, 24'sd0}},
    '{'{5'd10, 12'd1365, -24'sd30000, -24'sd123456, 24'sd654321, 1'b0}, 1'b0,
      '{24'sd0, 24'sd0}},
    '{'{5'd0, 12'd0, 24'sd1, 24'sd0, 24'sd65536, 1'b0}, 1'b0, '{24'sd0, 24'sd0}},
    '{'{5'd31, 12'd4095, -24'sd730000, 24'sd200000, 24'sd300000, 1'b0}, 1'b0,
      '{24'sd0, 24'sd0}},
    '{'{5'd31, 12'd4095, -24'sd772300, 24'sd200000, -24'sd300000, 1'b0}, 1'b0,
      '{24'sd0, 24'sd0}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int        state_mem [ST_DEPTH];
  out_beat_t awaited_outs [$];
  logic [16:0] hot_slots [HOT_SLOTS];
  int        mismatches = 0;
  int        snd_idle = 21;
  int        rcv_idle = 75;
  logic      hold_go = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  gated_linear_recurrence_scan dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned decay_q16(input logic signed [23:0] ld);
    longint ldx;
    longint unsigned t, u, n, f, idx, r, lo, hi, v;
    ldx = ld;
    if (ldx > 0) ldx = 0;
    t = longint'(-ldx);
    u = (t * longint'(LOG2E_Q16) + 32768) >> 16;
    n = u >> 16;
    if (n >= 17) return 0;
    f = u & 64'hFFFF;
    idx = f >> 12;
    r = f & 64'hFFF;
    lo = POW2_TAB[idx];
    hi = POW2_TAB[idx + 1];
    v = lo - (((lo - hi) * r + 2048) >> 12);
    if (n > 0) v = (v + (64'd1 << (n - 1))) >> n;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned d);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 32;
    while (bitv > d) bitv >>= 2;
    while (bitv != 0) begin
      if (d >= res + bitv) begin
        d -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint q16_round_sat(input longint v);
    longint q;
    q = (v + 32768) >>> 16;
    if (q > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (q < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return q;
  endfunction

  // advances the recurrent state of one slot and returns the beat it should emit
  function automatic out_beat_t scan_update(input in_beat_t b);
    int        slot;
    longint    prev, a, m, ns, ov;
    out_beat_t r;
    slot = (int'(b.layer) % LAYERS) * CHANNELS + (int'(b.channel) % CHANNELS);
    prev = state_mem[slot];
    a = longint'(decay_q16(b.log_decay));
    if (b.first_pos) m = longint'(Q_ONE);
    else m = longint'(int_sqrt((64'd1 << 32) - longint'(a * a)));
    ns = q16_round_sat(m * longint'(b.gated_x) + a * prev);
    state_mem[slot] = int'(ns);
    ov = q16_round_sat(longint'(b.branch_y) * ns);
    r.out_value = 24'(ov);
    r.new_state = 24'(ns);
    return r;
  endfunction

  function automatic logic signed [23:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2, 3, 4: return 24'(int'($urandom_range(0, 524287)) - 262144);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    if ($urandom_range(0, 99) < 85) begin
      {b.layer, b.channel} = hot_slots[$urandom_range(0, HOT_SLOTS - 1)];
    end else begin
      b.layer = 5'($urandom);
      b.channel = 12'($urandom);
    end
    b.first_pos = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: b.log_decay = '0;
      1: b.log_decay = 24'($urandom);
      2, 3: b.log_decay = 24'(-int'($urandom_range(0, 8388608)));
      default: b.log_decay = 24'(-int'($urandom_range(0, 150000)));
    endcase
    b.gated_x = rand_q16();
    b.branch_y = rand_q16();
    return b;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_LINES)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (awaited_outs.size() == 0) begin
      flag_mismatch("unexpected beat, out_value", int'(got.out_value), 0);
      return;
    end
    want = awaited_outs.pop_front();
    if (got.out_value !== want.out_value)
      flag_mismatch("out_value", int'(got.out_value), int'(want.out_value));
    if (got.new_state !== want.new_state)
      flag_mismatch("new_state", int'(got.new_state), int'(want.new_state));
  endtask

  task automatic offer(input in_beat_t b, input bit typed, input out_beat_t typed_want);
    out_beat_t want;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    want = scan_update(b);
    if (typed) want = typed_want;
    awaited_outs.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_outs.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_beat);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL gated_linear_recurrence_scan");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hot_slots[0] = {5'd31, 12'd4095};
    hot_slots[1] = {5'd0, 12'd0};
    for (int i = 2; i < HOT_SLOTS; i++) hot_slots[i] = 17'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 21 : (ph == 1) ? 75 : 0;
      rcv_idle = (ph == 0) ? 75 : (ph == 1) ? 21 : 0;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (ph == 2 && k == 40) hold_go <= 1'b1;
        offer(random_beat(), 1'b0, '0);
      end
      drain();
    end
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS gated_linear_recurrence_scan");
    end else begin
      $display("FAIL gated_linear_recurrence_scan");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/glrs_pkg.sv
rtl/glrs_mul.sv
rtl/glrs_sqrt.sv
rtl/glrs_store.sv
rtl/gated_linear_recurrence_scan.sv
rtl/glrs_chk.sv
verif/gated_linear_recurrence_scan_tb.sv
